[rtl/core/hsa_pkg.sv]
// shared types and constants for the hsv saturation adjust unit
package hsa_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int FIELD_W            = 16;
    localparam int SCALE_W            = 16;
    localparam int HUE_W              = 16;
    localparam int SECTOR_W           = 3;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    typedef struct packed {
        logic [FIELD_W-1:0] red_in;
        logic [FIELD_W-1:0] green_in;
        logic [FIELD_W-1:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] red_out;
        logic [FIELD_W-1:0] green_out;
        logic [FIELD_W-1:0] blue_out;
    } pix_out_t;

    // hue sectors of the six-sector rebuild
    typedef enum logic [SECTOR_W-1:0] {
        SECT_RED_YELLOW   = 3'd0,
        SECT_YELLOW_GREEN = 3'd1,
        SECT_GREEN_CYAN   = 3'd2,
        SECT_CYAN_BLUE    = 3'd3,
        SECT_BLUE_MAGENTA = 3'd4,
        SECT_MAGENTA_RED  = 3'd5
    } hsa_sector_t;

endpackage

[rtl/core/hsa_analyse.sv]
// first stage: max, min, range and the numerators and divisors of saturation and hue
module hsa_analyse #(
    parameter int COMPONENT_BITS = hsa_pkg::COMPONENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  hsa_pkg::pix_in_t              in_data,
    output logic                          valid_o,
    output logic [COMPONENT_BITS-1:0]     mx_o,
    output logic [2*COMPONENT_BITS+18:0]  num1_o,
    output logic [COMPONENT_BITS:0]       den1_o,
    output logic [COMPONENT_BITS+((COMPONENT_BITS > 17) ? COMPONENT_BITS : 17)+4:0] num2_o,
    output logic [COMPONENT_BITS+3:0]     den2_o
);
    import hsa_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int QW = (CB > 17) ? CB : 17;
    localparam int W1 = 2*CB + 19;
    localparam int W2 = CB + QW + 5;
    localparam logic [CB-1:0] FULL = {CB{1'b1}};

    logic [CB-1:0] r, g, b, mx, mn, rng;
    logic [CB+2:0] rng6, nn;
    logic [W1-1:0] num1;
    logic [CB:0]   den1;
    logic [W2-1:0] num2;
    logic [CB+3:0] den2;

    logic          valid_reg;
    logic [CB-1:0] mx_reg;
    logic [W1-1:0] num1_reg;
    logic [CB:0]   den1_reg;
    logic [W2-1:0] num2_reg;
    logic [CB+3:0] den2_reg;

    always_comb
    begin
        r = CB'(in_data.red_in);
        g = CB'(in_data.green_in);
        b = CB'(in_data.blue_in);
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        rng  = mx - mn;
        rng6 = (CB+3)'(rng) * (CB+3)'(6);

        // hue numerator, red tested first then green
        if (r == mx)
            nn = (g >= b) ? (CB+3)'(g - b) : rng6 - (CB+3)'(b - g);
        else if (g == mx)
            nn = (CB+3)'(b) + ((CB+3)'(rng) << 1) - (CB+3)'(r);
        else
            nn = (CB+3)'(r) + ((CB+3)'(rng) << 2) - (CB+3)'(g);

        // rounded division forms: (2*num + den) / (2*den)
        num1 = (W1'(rng) << 1) * W1'(FULL) + W1'(mx);
        den1 = (mx == '0) ? (CB+1)'(2) : {mx, 1'b0};

        if (rng == '0)
        begin
            num2 = '0;
            den2 = (CB+4)'(1);
        end
        else
        begin
            num2 = (W2'(nn) << (HUE_W + 1)) + W2'(rng6);
            den2 = {rng6, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg   <= mx;
            num1_reg <= num1;
            den1_reg <= den1;
            num2_reg <= num2;
            den2_reg <= den2;
        end
    end

    assign valid_o = valid_reg;
    assign mx_o    = mx_reg;
    assign num1_o  = num1_reg;
    assign den1_o  = den1_reg;
    assign num2_o  = num2_reg;
    assign den2_o  = den2_reg;

endmodule

[rtl/core/hsa_divider.sv]
// pipelined restoring divider, one quotient bit per stage, saturation and hue lanes side by side
module hsa_divider #(
    parameter int COMPONENT_BITS = hsa_pkg::COMPONENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_i,
    input  logic [COMPONENT_BITS-1:0]     mx_i,
    input  logic [2*COMPONENT_BITS+18:0]  num1_i,
    input  logic [COMPONENT_BITS:0]       den1_i,
    input  logic [COMPONENT_BITS+((COMPONENT_BITS > 17) ? COMPONENT_BITS : 17)+4:0] num2_i,
    input  logic [COMPONENT_BITS+3:0]     den2_i,
    output logic                          valid_o,
    output logic [COMPONENT_BITS-1:0]     mx_o,
    output logic [COMPONENT_BITS-1:0]     sat_o,
    output logic [hsa_pkg::HUE_W-1:0]     hue_o
);
    import hsa_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int QW = (CB > 17) ? CB : 17;
    localparam int W1 = 2*CB + 19;
    localparam int W2 = CB + QW + 5;

    logic          valid_reg [1:QW];
    logic [CB-1:0] mx_reg    [1:QW];
    logic [QW-1:0] q1_reg    [1:QW];
    logic [QW-1:0] q2_reg    [1:QW];
    logic [W1-1:0] rem1_reg  [1:QW-1];
    logic [CB:0]   den1_reg  [1:QW-1];
    logic [W2-1:0] rem2_reg  [1:QW-1];
    logic [CB+3:0] den2_reg  [1:QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int BIT = QW - 1 - k;

        logic          v_src;
        logic [CB-1:0] mx_src;
        logic [QW-1:0] q1_src, q2_src, q1_nxt, q2_nxt;
        logic [W1-1:0] rem1_src, rem1_nxt, sh1;
        logic [CB:0]   den1_src;
        logic [W2-1:0] rem2_src, rem2_nxt, sh2;
        logic [CB+3:0] den2_src;

        if (k == 0)
        begin : g_first
            assign v_src    = valid_i;
            assign mx_src   = mx_i;
            assign q1_src   = '0;
            assign q2_src   = '0;
            assign rem1_src = num1_i;
            assign den1_src = den1_i;
            assign rem2_src = num2_i;
            assign den2_src = den2_i;
        end
        else
        begin : g_next
            assign v_src    = valid_reg[k];
            assign mx_src   = mx_reg[k];
            assign q1_src   = q1_reg[k];
            assign q2_src   = q2_reg[k];
            assign rem1_src = rem1_reg[k];
            assign den1_src = den1_reg[k];
            assign rem2_src = rem2_reg[k];
            assign den2_src = den2_reg[k];
        end

        always_comb
        begin
            sh1 = W1'(den1_src) << BIT;
            sh2 = W2'(den2_src) << BIT;
            rem1_nxt = rem1_src;
            q1_nxt   = q1_src;
            rem2_nxt = rem2_src;
            q2_nxt   = q2_src;
            if (rem1_src >= sh1)
            begin
                rem1_nxt    = rem1_src - sh1;
                q1_nxt[BIT] = 1'b1;
            end
            if (rem2_src >= sh2)
            begin
                rem2_nxt    = rem2_src - sh2;
                q2_nxt[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mx_reg[k+1] <= mx_src;
                q1_reg[k+1] <= q1_nxt;
                q2_reg[k+1] <= q2_nxt;
            end
        end

        if (k < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem1_reg[k+1] <= rem1_nxt;
                    den1_reg[k+1] <= den1_src;
                    rem2_reg[k+1] <= rem2_nxt;
                    den2_reg[k+1] <= den2_src;
                end
            end
        end
    end

    assign valid_o = valid_reg[QW];
    assign mx_o    = mx_reg[QW];
    assign sat_o   = q1_reg[QW][CB-1:0];
    // a hue that rounds to a full turn wraps to zero
    assign hue_o   = q2_reg[QW][HUE_W-1:0];

endmodule

[rtl/core/hsa_rebuild.sv]
// saturation scaling, chroma and six-sector rebuild, ending in the output register
module hsa_rebuild #(
    parameter int COMPONENT_BITS = hsa_pkg::COMPONENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_i,
    input  logic [COMPONENT_BITS-1:0]     mx_i,
    input  logic [COMPONENT_BITS-1:0]     sat_i,
    input  logic [hsa_pkg::HUE_W-1:0]     hue_i,
    input  logic [hsa_pkg::SCALE_W-1:0]   scale,
    output logic                          out_valid,
    output hsa_pkg::pix_out_t             out_data
);
    import hsa_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int PW = CB + SCALE_W;
    localparam logic [CB-1:0] FULL = {CB{1'b1}};

    // stage 1: s * scale, sector and fraction
    logic [PW-1:0]       p1;
    logic [HUE_W+2:0]    dh;
    logic [HUE_W-1:0]    f;
    logic [HUE_W:0]      t1;
    hsa_sector_t         sect1;
    logic                v1_reg;
    logic [PW-1:0]       p1_reg;
    logic [HUE_W:0]      t1_reg;
    hsa_sector_t         sect1_reg;
    logic [CB-1:0]       mx1_reg;

    always_comb
    begin
        p1    = PW'(sat_i) * PW'(scale);
        dh    = (HUE_W+3)'(hue_i) * (HUE_W+3)'(6);
        sect1 = hsa_sector_t'(dh[HUE_W+2:HUE_W]);
        f     = dh[HUE_W-1:0];
        t1    = dh[HUE_W] ? ((HUE_W+1)'(1) << HUE_W) - (HUE_W+1)'(f) : (HUE_W+1)'(f);
    end

    // stage 2: rounded and clamped scaled saturation, then s2 * v
    logic [PW:0]         psum;
    logic [CB+8:0]       s2w;
    logic [CB-1:0]       s2;
    logic [2*CB-1:0]     y2;
    logic                v2_reg;
    logic [2*CB-1:0]     y2_reg;
    logic [HUE_W:0]      t2_reg;
    hsa_sector_t         sect2_reg;
    logic [CB-1:0]       mx2_reg;

    always_comb
    begin
        psum = (PW+1)'(p1_reg) + (PW+1)'(128);
        s2w  = psum[PW:8];
        s2   = (s2w > (CB+9)'(FULL)) ? FULL : s2w[CB-1:0];
        y2   = (2*CB)'(s2) * (2*CB)'(mx1_reg);
    end

    // stage 3: chroma = round(y / full), division by 2^n - 1 with folding
    logic [2*CB:0]       w3;
    logic [CB:0]         qh;
    logic [CB+1:0]       rr;
    logic [CB+1:0]       c3w;
    logic                v3_reg;
    logic [CB-1:0]       c3_reg;
    logic [HUE_W:0]      t3_reg;
    hsa_sector_t         sect3_reg;
    logic [CB-1:0]       mx3_reg;

    always_comb
    begin
        w3  = (2*CB+1)'(y2_reg) + (2*CB+1)'(FULL >> 1);
        qh  = w3[2*CB:CB];
        rr  = (CB+2)'(qh) + (CB+2)'(w3[CB-1:0]);
        c3w = (CB+2)'(qh)
            + (CB+2)'(rr >= (CB+2)'(FULL))
            + (CB+2)'(rr >= ((CB+2)'(FULL) << 1));
    end

    // stage 4: x = round(c * t / 2^16), m = v - c
    logic [CB+HUE_W:0]   prod;
    logic [CB+HUE_W+1:0] xsum;
    logic                v4_reg;
    logic [CB-1:0]       c4_reg, x4_reg, m4_reg;
    hsa_sector_t         sect4_reg;

    always_comb
    begin
        prod = (CB+HUE_W+1)'(c3_reg) * (CB+HUE_W+1)'(t3_reg);
        xsum = (CB+HUE_W+2)'(prod) + ((CB+HUE_W+2)'(1) << (HUE_W-1));
    end

    // stage 5: sector select and add m
    logic [CB-1:0]       ro, go, bo;
    logic [CB:0]         rs, gs, bs;
    logic                v5_reg;
    pix_out_t            out_reg;

    always_comb
    begin
        case (sect4_reg)
            SECT_RED_YELLOW:
            begin
                ro = c4_reg; go = x4_reg; bo = '0;
            end
            SECT_YELLOW_GREEN:
            begin
                ro = x4_reg; go = c4_reg; bo = '0;
            end
            SECT_GREEN_CYAN:
            begin
                ro = '0; go = c4_reg; bo = x4_reg;
            end
            SECT_CYAN_BLUE:
            begin
                ro = '0; go = x4_reg; bo = c4_reg;
            end
            SECT_BLUE_MAGENTA:
            begin
                ro = x4_reg; go = '0; bo = c4_reg;
            end
            default:
            begin
                ro = c4_reg; go = '0; bo = x4_reg;
            end
        endcase
        rs = (CB+1)'(ro) + (CB+1)'(m4_reg);
        gs = (CB+1)'(go) + (CB+1)'(m4_reg);
        bs = (CB+1)'(bo) + (CB+1)'(m4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_i;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= p1;
            t1_reg    <= t1;
            sect1_reg <= sect1;
            mx1_reg   <= mx_i;

            y2_reg    <= y2;
            t2_reg    <= t1_reg;
            sect2_reg <= sect1_reg;
            mx2_reg   <= mx1_reg;

            c3_reg    <= c3w[CB-1:0];
            t3_reg    <= t2_reg;
            sect3_reg <= sect2_reg;
            mx3_reg   <= mx2_reg;

            c4_reg    <= c3_reg;
            x4_reg    <= xsum[CB+HUE_W-1:HUE_W];
            m4_reg    <= mx3_reg - c3_reg;
            sect4_reg <= sect3_reg;

            out_reg.red_out   <= FIELD_W'(rs);
            out_reg.green_out <= FIELD_W'(gs);
            out_reg.blue_out  <= FIELD_W'(bs);
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = out_reg;

endmodule

[rtl/core/hsv_saturation_adjust_unit.sv]
// top level of the hsv saturation adjust unit
//
// one rgb pixel in, one adjusted rgb pixel out. both sides use valid/ready;
// a beat moves when valid and ready are high at the same rising edge.
// in_data carries red_in, green_in, blue_in, out_data the adjusted
// red_out, green_out, blue_out, all unsigned with 2^COMPONENT_BITS - 1
// meaning 1.0.
// cfg_we/cfg_data write saturation_scale (unsigned q8.8, 256 leaves the
// pixel as it was); write it only while no pixel is in flight.
// throughput: one pixel per cycle unless the output stalls; every pixel
// is independent. the saturation and hue quotients come from two restoring
// dividers, side by side, which produce one quotient bit per stage.
// reset clears every valid bit and sets saturation_scale back to 256.
// when the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated, and
// empty slots inside the pipeline travel down it like beats.
module hsv_saturation_adjust_unit #(
    parameter int COMPONENT_BITS = hsa_pkg::COMPONENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hsa_pkg::pix_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hsa_pkg::pix_out_t             out_data,
    input  logic                          cfg_we,
    input  logic [hsa_pkg::SCALE_W-1:0]   cfg_data
);
    import hsa_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int QW = (CB > 17) ? CB : 17;
    localparam int W1 = 2*CB + 19;
    localparam int W2 = CB + QW + 5;

    logic [SCALE_W-1:0] scale_reg;
    logic               en;

    // analyse -> divider
    logic               a_valid;
    logic [CB-1:0]      a_mx;
    logic [W1-1:0]      a_num1;
    logic [CB:0]        a_den1;
    logic [W2-1:0]      a_num2;
    logic [CB+3:0]      a_den2;

    // divider -> rebuild
    logic               d_valid;
    logic [CB-1:0]      d_mx;
    logic [CB-1:0]      d_sat;
    logic [HUE_W-1:0]   d_hue;

    // saturation multiplier register, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg_we)
            scale_reg <= cfg_data;
    end

    // every stage moves together unless the output beat is stuck
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    hsa_analyse #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_analyse (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_data  (in_data),
        .valid_o  (a_valid),
        .mx_o     (a_mx),
        .num1_o   (a_num1),
        .den1_o   (a_den1),
        .num2_o   (a_num2),
        .den2_o   (a_den2)
    );

    // saturation = round(range*full/max), hue = round(n*65536/(6*range))
    hsa_divider #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (a_valid),
        .mx_i    (a_mx),
        .num1_i  (a_num1),
        .den1_i  (a_den1),
        .num2_i  (a_num2),
        .den2_i  (a_den2),
        .valid_o (d_valid),
        .mx_o    (d_mx),
        .sat_o   (d_sat),
        .hue_o   (d_hue)
    );

    hsa_rebuild #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_rebuild (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_i   (d_valid),
        .mx_i      (d_mx),
        .sat_i     (d_sat),
        .hue_i     (d_hue),
        .scale     (scale_reg),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

[test/hsv_saturation_adjust_unit_tb.sv]
// self-checking testbench for the hsv saturation adjust unit
`timescale 1ns / 100ps

module hsv_saturation_adjust_unit_tb;
    import hsa_pkg::*;

    localparam int FULL      = 65535;
    localparam int LATENCY   = 23;
    localparam int WDOG_MAX  = 20000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    pix_in_t             in_data;
    logic                out_valid;
    logic                out_ready;
    pix_out_t            out_data;
    logic                cfg_we;
    logic [SCALE_W-1:0]  cfg_data;

    // scale as the unit should currently hold it
    logic [SCALE_W-1:0]  model_scale;
    // adjusted pixels not yet seen at the output, oldest first
    pix_out_t            pending_pixels[$];
    int                  mismatch_count;
    int                  beats_sent;
    int                  beats_checked;
    int                  idle_cycles;
    bit                  timed_out;
    // idling on/off for both sides
    bit                  allow_idle;

    hsv_saturation_adjust_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // rounded division with ties going up
    function automatic longint unsigned div_round(longint unsigned num,
                                                  longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    // works out the adjusted pixel for one input beat at the current scale
    function automatic pix_out_t adjust_pixel(pix_in_t px, logic [SCALE_W-1:0] scale);
        longint unsigned r, g, b, mx, mn, rng, sat, sat2, hue, num, c, m, x, t, dh, f;
        hsa_sector_t     sect;
        pix_out_t        res;
        r = px.red_in;
        g = px.green_in;
        b = px.blue_in;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        rng = mx - mn;
        sat = 0;
        hue = 0;
        if (mx > 0)
            sat = div_round(rng * FULL, mx);
        if (rng > 0)
        begin
            // red tested first, then green
            if (r == mx)
                num = (g >= b) ? (g - b) : (6 * rng - (b - g));
            else if (g == mx)
                num = b + 2 * rng - r;
            else
                num = r + 4 * rng - g;
            hue = div_round(num * 65536, 6 * rng) & 65535;
        end
        sat2 = div_round(sat * scale, 256);
        if (sat2 > FULL) sat2 = FULL;
        c = div_round(sat2 * mx, FULL);
        m = mx - c;
        dh = hue * 6;
        sect = hsa_sector_t'(dh >> 16);
        f = dh & 65535;
        t = dh[16] ? (65536 - f) : f;
        x = div_round(c * t, 65536);
        case (sect)
            SECT_RED_YELLOW:
            begin
                res.red_out = 16'(c); res.green_out = 16'(x); res.blue_out = '0;
            end
            SECT_YELLOW_GREEN:
            begin
                res.red_out = 16'(x); res.green_out = 16'(c); res.blue_out = '0;
            end
            SECT_GREEN_CYAN:
            begin
                res.red_out = '0; res.green_out = 16'(c); res.blue_out = 16'(x);
            end
            SECT_CYAN_BLUE:
            begin
                res.red_out = '0; res.green_out = 16'(x); res.blue_out = 16'(c);
            end
            SECT_BLUE_MAGENTA:
            begin
                res.red_out = 16'(x); res.green_out = '0; res.blue_out = 16'(c);
            end
            default:
            begin
                res.red_out = 16'(c); res.green_out = '0; res.blue_out = 16'(x);
            end
        endcase
        res.red_out   = 16'(res.red_out + m);
        res.green_out = 16'(res.green_out + m);
        res.blue_out  = 16'(res.blue_out + m);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("error: beat %0d %s got %0d expected %0d", beats_checked, what, got, want);
        mismatch_count++;
    endtask

    // sends one pixel, with a random gap first, and records what should come back;
    // valid stays high after the beat so the next pixel can follow straight on
    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        while (allow_idle && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{red_in: r, green_in: g, blue_in: b};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // beat taken at this edge
        pending_pixels.push_back(adjust_pixel('{red_in: r, green_in: g, blue_in: b},
                                              model_scale));
        beats_sent++;
    endtask

    // waits for every expected beat, then for the pipeline to drain
    task automatic drain_unit();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_scale(logic [SCALE_W-1:0] value);
        drain_unit();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        model_scale  = value;
    endtask

    // receiver: random stalls, compares each beat with the oldest expectation
    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_pixels.size() == 0)
                    report_mismatch("beat with nothing pending", 1, 0);
                else
                begin
                    want = pending_pixels.pop_front();
                    if (out_data.red_out !== want.red_out)
                        report_mismatch("red", out_data.red_out, want.red_out);
                    if (out_data.green_out !== want.green_out)
                        report_mismatch("green", out_data.green_out, want.green_out);
                    if (out_data.blue_out !== want.blue_out)
                        report_mismatch("blue", out_data.blue_out, want.blue_out);
                end
                beats_checked++;
            end
            out_ready <= !(allow_idle && $urandom_range(99) < 9);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX)
        begin
            $display("watchdog: no progress, %0d beats still expected",
                     pending_pixels.size());
            $display("hsv_saturation_adjust_unit: mismatch");
            $finish;
        end
    end

    // extremes, greys, black, one pixel per sector and a hue that rounds to a full turn
    task automatic test_directed();
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h8000, 16'h8000, 16'h8000);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h8000, 16'h0000);
        send_pixel(16'h8000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'h8000);
        send_pixel(16'h0000, 16'h8000, 16'hFFFF);
        send_pixel(16'h8000, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h8000);
        send_pixel(16'hFFFF, 16'h0000, 16'h0001);
        send_pixel(16'hFFFF, 16'hFFFE, 16'hFFFF);
        send_pixel(16'h0001, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
        send_pixel(16'h5555, 16'hAAAA, 16'h1234);
    endtask

    // random pixels, biased towards edge values now and then
    task automatic test_random(int count);
        logic [15:0] comp[3];
        for (int i = 0; i < count; i++)
        begin
            foreach (comp[k])
            begin
                case ($urandom_range(7))
                    0:       comp[k] = 16'h0000;
                    1:       comp[k] = 16'hFFFF;
                    default: comp[k] = 16'($urandom);
                endcase
            end
            // sometimes make two components equal to exercise the tie order
            if ($urandom_range(9) == 0)
                comp[1] = comp[0];
            send_pixel(comp[0], comp[1], comp[2]);
        end
    endtask

    // sweeps the scale through several values, extremes included
    task automatic test_scales();
        logic [SCALE_W-1:0] scales[6] = '{16'd0, 16'hFFFF, 16'd128, 16'd512, 16'd256, 16'd1};
        foreach (scales[i])
        begin
            write_scale(scales[i]);
            test_directed();
            test_random(60);
        end
        write_scale(SCALE_W'($urandom));
        test_random(60);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        model_scale    = SCALE_RESET;
        mismatch_count = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        idle_cycles    = 0;
        allow_idle     = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset scale first
        test_directed();
        test_random(40);
        // stretch without any idling on either side
        allow_idle = 1'b0;
        test_random(80);
        allow_idle = 1'b1;
        test_scales();

        drain_unit();
        $display("covered %0d pixels over eight scale settings, %0d output beats checked",
                 beats_sent, beats_checked);
        if (mismatch_count == 0)
            $display("hsv_saturation_adjust_unit: match");
        else
            $display("hsv_saturation_adjust_unit: mismatch");
        $finish;
    end

endmodule
